// ===== rtl/integer_matrix_multiply_unit_defines.svh =====
// assertion helpers for the matrix multiply top level
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/imm_pkg.sv =====
package imm_pkg;

    // fixed field widths
    localparam int DIM_W   = 4;
    localparam int IDX_W   = 3;
    localparam int SUM_W   = 35;
    localparam int CFG_A_W = 2;

    // defaults for the top level parameters
    localparam int DEF_MAX_DIM    = 8;
    localparam int DEF_ELEM_WIDTH = 16;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMPUTE,
        ST_DRAIN
    } t_state;

    // control that travels with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > max_v) begin
            res = max_v;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/imm_ram.sv =====
module imm_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/imm_mac.sv =====
module imm_mac #(
    parameter int ELEM_WIDTH = imm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [ELEM_WIDTH-1:0]      i_a,
    input  logic [ELEM_WIDTH-1:0]      i_b,
    input  imm_pkg::t_tag              i_tag,
    output logic                       o_res_valid,
    output logic [imm_pkg::SUM_W-1:0]  o_res_sum,
    output imm_pkg::t_tag              o_res_tag
);

    import imm_pkg::*;

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int WIDE_W = PROD_W + SUM_W;

    logic signed [PROD_W-1:0] r_prod;
    t_tag                     r_tag;
    logic [SUM_W-1:0]         r_acc;
    logic signed [WIDE_W-1:0] prod_ext;
    logic [SUM_W-1:0]         n_sum;

    // product stage tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    // signed multiply, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    // accumulate modulo the sum width, restart on the first step of a dot product
    assign prod_ext = WIDE_W'(r_prod);
    assign n_sum    = r_tag.first ? prod_ext[SUM_W-1:0] : r_acc + prod_ext[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en && r_tag.valid) begin
            r_acc <= n_sum;
        end
    end

    assign o_res_valid = i_en && r_tag.valid && r_tag.last_k;
    assign o_res_sum   = n_sum;
    assign o_res_tag   = r_tag;

endmodule

// ===== rtl/integer_matrix_multiply_unit.sv =====
// Signed matrix product C = A x B. Set rows_a, inner_dim and cols_b, then send the
// elements of A and then of B, both row-major, one word per cycle with no stall.
// The final B word starts the product: input stalls while one multiply-accumulate
// per cycle, while the output does not stall, walks rows_a*cols_b*inner_dim steps,
// since each store has a single read port, and then while the last steps pass the
// read, multiply and add registers. Results leave row-major with row, column and a
// last flag; output stall freezes that pipeline. Loading may start while the last
// result still waits at the output.
`include "integer_matrix_multiply_unit_defines.svh"

module integer_matrix_multiply_unit #(
    parameter int  MAX_DIM    = imm_pkg::DEF_MAX_DIM,
    parameter int  ELEM_WIDTH = imm_pkg::DEF_ELEM_WIDTH,
    localparam int DEPTH      = MAX_DIM * MAX_DIM,
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [imm_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]    i_cfg_data,
    // element input
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ELEM_WIDTH-1:0]        i_element_value,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [imm_pkg::SUM_W-1:0]    o_product_value,
    output logic [imm_pkg::IDX_W-1:0]    o_out_row,
    output logic [imm_pkg::IDX_W-1:0]    o_out_col,
    output logic                         o_last_element
);

    import imm_pkg::*;

    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

    t_state            r_state, n_state;
    logic [DIM_W-1:0]  r_rows_a, r_inner_dim, r_cols_b;
    logic [DIM_W-1:0]  eff_m, eff_n, eff_p;
    logic [DIM_W-1:0]  load_rows, load_cols;
    logic              r_phase_b;
    logic [DIM_W-1:0]  r_lr, r_lc;
    logic [DIM_W-1:0]  r_cm, r_cn, r_cp;
    logic [DIM_W-1:0]  r_ci, r_cj, r_ck;
    logic              cfg_wr, in_acc, load_done, adv, issue;
    logic              k_end, j_end, i_end;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [ELEM_WIDTH-1:0] a_data, b_data;
    t_tag              issue_tag, r_s1_tag, res_tag;
    logic              res_valid;
    logic [SUM_W-1:0]  res_sum;
    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_sum;
    logic [IDX_W-1:0]  r_out_row, r_out_col;
    logic              r_out_last;

    // effective dimensions
    assign eff_m = eff_dim(r_rows_a, MAX_D);
    assign eff_n = eff_dim(r_inner_dim, MAX_D);
    assign eff_p = eff_dim(r_cols_b, MAX_D);

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(1);
            r_inner_dim <= DIM_W'(1);
            r_cols_b    <= DIM_W'(1);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // load side: A is rows_a x inner_dim, B is inner_dim x cols_b
    assign load_rows = r_phase_b ? eff_n : eff_m;
    assign load_cols = r_phase_b ? eff_p : eff_n;
    assign in_acc    = i_in_valid && !o_in_stall;
    assign load_done = in_acc && r_phase_b && (r_lr == eff_n - 1'b1)
                       && (r_lc == eff_p - 1'b1);
    assign wr_addr   = ADDR_W'(int'(r_lr) * MAX_DIM + int'(r_lc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_b <= 1'b0;
            r_lr      <= '0;
            r_lc      <= '0;
        end else if (cfg_wr) begin
            r_phase_b <= 1'b0;
            r_lr      <= '0;
            r_lc      <= '0;
        end else if (in_acc) begin
            if (r_lc != load_cols - 1'b1) begin
                r_lc <= r_lc + 1'b1;
            end else begin
                r_lc <= '0;
                if (r_lr != load_rows - 1'b1) begin
                    r_lr <= r_lr + 1'b1;
                end else begin
                    r_lr      <= '0;
                    r_phase_b <= !r_phase_b;
                end
            end
        end
    end

    // compute side: walk i, j, k with one read per store each cycle unless the output stalls
    assign adv   = !(r_out_valid && i_out_stall);
    assign issue = (r_state == ST_COMPUTE) && adv;
    assign k_end = (r_ck == r_cn - 1'b1);
    assign j_end = (r_cj == r_cp - 1'b1);
    assign i_end = (r_ci == r_cm - 1'b1);

    assign rd_addr_a = ADDR_W'(int'(r_ci) * MAX_DIM + int'(r_ck));
    assign rd_addr_b = ADDR_W'(int'(r_ck) * MAX_DIM + int'(r_cj));

    always_comb begin
        issue_tag        = '0;
        issue_tag.valid  = issue;
        issue_tag.first  = (r_ck == '0);
        issue_tag.last_k = k_end;
        issue_tag.last   = k_end && j_end && i_end;
        issue_tag.row    = r_ci[IDX_W-1:0];
        issue_tag.col    = r_cj[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0;
            r_cj <= '0;
            r_ck <= '0;
            r_cm <= DIM_W'(1);
            r_cn <= DIM_W'(1);
            r_cp <= DIM_W'(1);
        end else if (load_done) begin
            r_ci <= '0;
            r_cj <= '0;
            r_ck <= '0;
            r_cm <= eff_m;
            r_cn <= eff_n;
            r_cp <= eff_p;
        end else if (issue) begin
            if (!k_end) begin
                r_ck <= r_ck + 1'b1;
            end else begin
                r_ck <= '0;
                if (!j_end) begin
                    r_cj <= r_cj + 1'b1;
                end else begin
                    r_cj <= '0;
                    r_ci <= r_ci + 1'b1;
                end
            end
        end
    end

    // tag lines up with the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else if (adv) begin
            r_s1_tag <= issue_tag;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (load_done) begin
                    n_state = ST_COMPUTE;
                end
            end
            ST_COMPUTE: begin
                if (issue && k_end && j_end && i_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (res_valid && res_tag.last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // element stores
    imm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && !r_phase_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (a_data)
    );

    imm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && r_phase_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (b_data)
    );

    // multiply-accumulate pipeline
    imm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_a         (a_data),
        .i_b         (b_data),
        .i_tag       (r_s1_tag),
        .o_res_valid (res_valid),
        .o_res_sum   (res_sum),
        .o_res_tag   (res_tag)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_sum  <= res_sum;
            r_out_row  <= res_tag.row;
            r_out_col  <= res_tag.col;
            r_out_last <= res_tag.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_product_value = r_out_sum;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_element  = r_out_last;

    // checks
    `IMM_ASSERT_NOW(a_load_in_range, i_clk, i_rst_n, r_state == ST_LOAD,
        (r_lr < load_rows) && (r_lc < load_cols), "load position outside matrix")
    `IMM_ASSERT_NOW(a_issue_in_range, i_clk, i_rst_n, r_state == ST_COMPUTE,
        (r_ci < r_cm) && (r_cj < r_cp) && (r_ck < r_cn), "compute position outside matrix")
    `IMM_ASSERT_NEXT(a_freeze_on_stall, i_clk, i_rst_n,
        r_out_valid && i_out_stall && r_state == ST_COMPUTE,
        $stable(r_ck) && $stable(r_cj) && $stable(r_ci), "issue advanced while output full")
    `IMM_ASSERT_NEXT(a_drain_ends, i_clk, i_rst_n, res_valid && res_tag.last,
        r_state == ST_LOAD && o_out_valid && o_last_element, "final result did not re-arm")

endmodule

// ===== sim/testbench.sv =====
module testbench;

    import imm_pkg::*;

    localparam int ELEM_W      = DEF_ELEM_WIDTH;
    localparam int MAX_SIDE    = DEF_MAX_DIM;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_BUDGET = 470;
    localparam int CYCLE_LIMIT = 1000000;

    // index past the register list: writes only restart loading
    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {PACE_FREE, PACE_BUSY} t_pace;
    typedef enum logic {ROW_ELEM, ROW_CFG} t_row_kind;

    typedef struct {
        logic signed [SUM_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    is_last;
    } t_product;

    // typed expectations are single-element products at row 0, col 0
    typedef struct {
        t_row_kind               kind;
        logic [CFG_A_W-1:0]      index;
        logic [DIM_W-1:0]        data;
        logic [ELEM_W-1:0]       value;
        bit                      has_exp;
        logic signed [SUM_W-1:0] exp_value;
    } t_stim_row;

    // dut signals, the driven inputs all known from time zero
    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_A_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic [ELEM_W-1:0]    in_data = '0;
    logic                 out_stall = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [SUM_W-1:0]     o_product_value;
    logic [IDX_W-1:0]     o_out_row;
    logic [IDX_W-1:0]     o_out_col;
    logic                 o_last_element;

    // predictor state
    logic [DIM_W-1:0]        rows_reg = DIM_W'(1);
    logic [DIM_W-1:0]        inner_reg = DIM_W'(1);
    logic [DIM_W-1:0]        cols_reg = DIM_W'(1);
    logic signed [ELEM_W-1:0] a_store [STORE_DEPTH] = '{default: '0};
    logic signed [ELEM_W-1:0] b_store [STORE_DEPTH] = '{default: '0};
    logic [7:0]              load_count = '0;
    t_product                pending_products [$];

    t_pace     pace = PACE_BUSY;
    bit        hold_req = 1'b0;
    int        err_count = 0;
    int        items_sent = 0;
    int        results_checked = 0;
    int        products_done = 0;
    int        cfg_writes = 0;
    int        cycle_count = 0;
    t_stim_row directed_rows [$];

    integer_matrix_multiply_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_element_value (in_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_product_value (o_product_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_element  (o_last_element)
    );

    always #10 i_clk = ~i_clk;

    // zero acts as one, above the limit acts as the limit
    function automatic int dim_in_use(input logic [DIM_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > MAX_SIDE) return MAX_SIDE;
        return int'(raw);
    endfunction

    function automatic int words_per_pass();
        int m, n, p;
        m = dim_in_use(rows_reg);
        n = dim_in_use(inner_reg);
        p = dim_in_use(cols_reg);
        return m * n + n * p;
    endfunction

    // register write: any index restarts the load pass
    task automatic apply_register(input logic [CFG_A_W-1:0] idx, input logic [DIM_W-1:0] val);
        case (idx)
            CFG_ROWS_A:    rows_reg = val;
            CFG_INNER_DIM: inner_reg = val;
            CFG_COLS_B:    cols_reg = val;
            default: ;
        endcase
        load_count = '0;
    endtask

    // store one element, and on the final b word produce the whole product
    task automatic absorb_element(input logic [ELEM_W-1:0] raw);
        int m, n, p, na, nb, cnt, i, j, k;
        logic signed [SUM_W-1:0] acc;
        t_product res;
        m = dim_in_use(rows_reg);
        n = dim_in_use(inner_reg);
        p = dim_in_use(cols_reg);
        na = m * n;
        nb = n * p;
        cnt = int'(load_count);
        if (cnt >= na + nb) cnt = 0;
        if (cnt < na) begin
            a_store[(cnt / n) * MAX_SIDE + cnt % n] = raw;
        end else begin
            b_store[((cnt - na) / p) * MAX_SIDE + (cnt - na) % p] = raw;
        end
        cnt++;
        if (cnt == na + nb) begin
            for (i = 0; i < m; i++) begin
                for (j = 0; j < p; j++) begin
                    acc = '0;
                    for (k = 0; k < n; k++) begin
                        acc = acc + a_store[i * MAX_SIDE + k] * b_store[k * MAX_SIDE + j];
                    end
                    res.value = acc;
                    res.row = IDX_W'(i);
                    res.col = IDX_W'(j);
                    res.is_last = (i == m - 1) && (j == p - 1);
                    pending_products.push_back(res);
                end
            end
            cnt = 0;
            products_done++;
        end
        load_count = 8'(cnt);
    endtask

    // compare one output word with the oldest expectation
    task automatic check_product();
        t_product want;
        if (pending_products.size() == 0) begin
            $display("%0t unexpected result: value %0d row %0d col %0d last %0d", $time,
                     $signed(o_product_value), o_out_row, o_out_col, o_last_element);
            err_count++;
        end else begin
            want = pending_products.pop_front();
            results_checked++;
            if (o_product_value !== want.value) begin
                $display("%0t value mismatch: expected %0d, got %0d", $time, want.value,
                         $signed(o_product_value));
                err_count++;
            end
            if (o_out_row !== want.row) begin
                $display("%0t row mismatch: expected %0d, got %0d", $time, want.row, o_out_row);
                err_count++;
            end
            if (o_out_col !== want.col) begin
                $display("%0t col mismatch: expected %0d, got %0d", $time, want.col, o_out_col);
                err_count++;
            end
            if (o_last_element !== want.is_last) begin
                $display("%0t last flag mismatch: expected %0d, got %0d", $time, want.is_last,
                         o_last_element);
                err_count++;
            end
        end
    endtask

    // watch all three handshakes at the rising edge
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) apply_register(cfg_index, cfg_data);
            if (in_valid && !o_in_stall) absorb_element(in_data);
            if (o_out_valid && !out_stall) check_product();
        end
    end

    // cycle counter guarding against a hang
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("[integer_matrix_multiply_unit] ERROR");
            $finish;
        end
    end

    // output stall: short bursts, rare long ones, and the requested hold-off
    initial begin
        int r, len;
        logic st;
        forever begin
            r = $urandom_range(0, 99);
            if (hold_req) begin
                hold_req = 1'b0;
                st = 1'b1;
                len = HOLD_CYCLES;
            end else if (pace == PACE_FREE) begin
                st = 1'b0;
                len = 1;
            end else if (r < 60) begin
                st = 1'b0;
                len = $urandom_range(1, 8);
            end else if (r < 95) begin
                st = 1'b1;
                len = $urandom_range(1, 3);
            end else begin
                st = 1'b1;
                len = $urandom_range(20, 80);
            end
            out_stall <= st;
            repeat (len) @(negedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (pace == PACE_FREE) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        logic [DIM_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 60) return DIM_W'($urandom_range(1, 3));
        if (r < 80) return DIM_W'($urandom_range(4, 7));
        if (r < 90) return DIM_W'(MAX_SIDE);
        // out of range raw values: zero or above the limit
        v = DIM_W'($urandom_range(8, 15));
        if (v == DIM_W'(MAX_SIDE)) v = '0;
        return v;
    endfunction

    function automatic logic [ELEM_W-1:0] rand_element(input bit extreme);
        int r;
        r = $urandom_range(0, 19);
        if (extreme) return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r == 2) return '0;
        return ELEM_W'($urandom);
    endfunction

    // tasks below start and end at a falling edge
    task automatic send_word(input logic [ELEM_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data <= v;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pass(input int count, input bit extreme);
        repeat (count) send_word(rand_element(extreme));
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_products.size() != 0) @(negedge i_clk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_cfg(input logic [CFG_A_W-1:0] idx, input logic [DIM_W-1:0] val);
        wait_results();
        repeat (SETTLE) @(negedge i_clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
                              input logic [DIM_W-1:0] p);
        write_cfg(CFG_ROWS_A, m);
        write_cfg(CFG_INNER_DIM, n);
        write_cfg(CFG_COLS_B, p);
    endtask

    function automatic t_stim_row elem_row(input logic [ELEM_W-1:0] v, input bit has,
                                           input logic signed [SUM_W-1:0] e);
        t_stim_row s;
        s.kind = ROW_ELEM;
        s.index = '0;
        s.data = '0;
        s.value = v;
        s.has_exp = has;
        s.exp_value = e;
        return s;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_A_W-1:0] idx,
                                          input logic [DIM_W-1:0] val);
        t_stim_row s;
        s.kind = ROW_CFG;
        s.index = idx;
        s.data = val;
        s.value = '0;
        s.has_exp = 1'b0;
        s.exp_value = '0;
        return s;
    endfunction

    initial begin
        int r, words, k;
        bit extreme;
        logic [CFG_A_W-1:0] idx;

        // directed rows, dimensions start at one after reset
        directed_rows.push_back(elem_row(16'sd3, 1'b0, '0));
        directed_rows.push_back(elem_row(-16'sd5, 1'b1, -35'sd15));
        directed_rows.push_back(elem_row(16'h8000, 1'b0, '0));
        directed_rows.push_back(elem_row(16'h8000, 1'b1, 35'sd1073741824));
        // zero dimensions act as one
        directed_rows.push_back(cfg_row(CFG_ROWS_A, '0));
        directed_rows.push_back(cfg_row(CFG_INNER_DIM, '0));
        directed_rows.push_back(cfg_row(CFG_COLS_B, '0));
        directed_rows.push_back(elem_row(16'h7fff, 1'b0, '0));
        directed_rows.push_back(elem_row(16'h8000, 1'b1, -35'sd1073709056));
        // write past the list in mid load restarts the pass
        directed_rows.push_back(elem_row(16'sd7, 1'b0, '0));
        directed_rows.push_back(cfg_row(CFG_UNUSED, DIM_W'(9)));
        directed_rows.push_back(elem_row(16'sd2, 1'b0, '0));
        directed_rows.push_back(elem_row(16'sd11, 1'b1, 35'sd22));
        // inner dimension above the limit acts as eight: largest positive sum
        directed_rows.push_back(cfg_row(CFG_INNER_DIM, DIM_W'(15)));
        for (k = 0; k < 15; k++) directed_rows.push_back(elem_row(16'h8000, 1'b0, '0));
        directed_rows.push_back(elem_row(16'h8000, 1'b1, 35'sd8589934592));

        repeat (7) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed rows
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_cfg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                send_word(directed_rows[i].value);
                if (directed_rows[i].has_exp) begin
                    if (pending_products.size() == 0 ||
                        pending_products[$].value !== directed_rows[i].exp_value ||
                        pending_products[$].row !== '0 || pending_products[$].col !== '0 ||
                        pending_products[$].is_last !== 1'b1) begin
                        $display("%0t directed row %0d: expected %0d, predicted %0d", $time,
                                 i, directed_rows[i].exp_value,
                                 (pending_products.size() == 0) ? '0 : pending_products[$].value);
                        err_count++;
                    end
                end
            end
        end

        // long output hold-off while the sender keeps pushing
        pace = PACE_FREE;
        write_dims(DIM_W'(4), DIM_W'(4), DIM_W'(4));
        hold_req = 1'b1;
        send_pass(2 * words_per_pass(), 1'b0);
        wait_results();

        // full size pass at the most negative sums
        pace = PACE_BUSY;
        write_dims(DIM_W'(MAX_SIDE), DIM_W'(MAX_SIDE), DIM_W'(MAX_SIDE));
        repeat (MAX_SIDE * MAX_SIDE) send_word(16'h8000);
        repeat (MAX_SIDE * MAX_SIDE) send_word(16'h7fff);

        // random passes, mostly well formed, some cut short by a restart
        write_dims(pick_dim(), pick_dim(), pick_dim());
        while (items_sent < ITEM_BUDGET) begin
            r = $urandom_range(0, 99);
            pace = ($urandom_range(0, 4) == 0) ? PACE_FREE : PACE_BUSY;
            extreme = ($urandom_range(0, 9) == 0);
            if (r < 35) begin
                write_dims(pick_dim(), pick_dim(), pick_dim());
            end else if (r < 40) begin
                write_cfg(CFG_UNUSED, DIM_W'($urandom));
            end
            words = words_per_pass();
            if (r >= 88) begin
                send_pass($urandom_range(1, words - 1), extreme);
                idx = CFG_A_W'($urandom_range(0, 3));
                write_cfg(idx, pick_dim());
            end else begin
                send_pass(words, extreme);
            end
            // sender pause until every result is out
            if ($urandom_range(0, 9) == 0) wait_results();
        end

        pace = PACE_FREE;
        wait_results();
        repeat (TAIL) @(negedge i_clk);

        $display("covered %0d elements, %0d products, %0d results, %0d register writes",
                 items_sent, products_done, results_checked, cfg_writes);
        $display("dims from 1 to 8 incl. zero and oversize codes, output hold of %0d cycles",
                 HOLD_CYCLES);
        if (err_count == 0 && pending_products.size() == 0) begin
            $display("[integer_matrix_multiply_unit] OK");
        end else begin
            $display("[integer_matrix_multiply_unit] ERROR");
        end
        $finish;
    end

endmodule
